// ===== rtl/core/etp_pkg.sv =====
package etp_pkg;

  localparam int DATA_W           = 32;
  localparam int ID_W             = 16;
  localparam int WGT_W            = 3;
  localparam int REQ_W            = 16;
  localparam int ENTRIES_DEF      = 64;
  localparam int FIXED_SCALE_DEF  = 1000;
  localparam int MAX_WEIGHT_DEF   = 5;
  localparam logic [DATA_W-1:0] DEADLINE_INIT = 32'h7FFF_FFFF;
  localparam logic [15:0]       QUANTUM_RST   = 16'd1000;

  typedef enum logic [2:0] {
    OP_CREATE = 3'd0,
    OP_WAKE   = 3'd1,
    OP_CHARGE = 3'd2,
    OP_SETATTR = 3'd3,
    OP_PICK   = 3'd4,
    OP_TICK   = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    MODE_FREE  = 2'd0,
    MODE_RUN   = 2'd1,
    MODE_SLEEP = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    OUTC_YIELD = 2'd0,
    OUTC_SLEEP = 2'd1,
    OUTC_EXIT  = 2'd2
  } outc_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_MUL,
    ST_DIV,
    ST_WAIT,
    ST_WRITE,
    ST_TICK,
    ST_PICK,
    ST_DRAIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [WGT_W-1:0]  weight;
    logic [REQ_W-1:0]  request;
    logic [DATA_W-1:0] vstart;
    logic [DATA_W-1:0] used;
    logic [DATA_W-1:0] eligible;
    logic [DATA_W-1:0] deadline;
  } entry_t;

endpackage

// ===== rtl/core/etp_div.sv =====
module etp_div import etp_pkg::*; #(
  parameter int DV_W = 11
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DATA_W-1:0] dividend_i,
  input  logic [DV_W-1:0]   divisor_i,
  output logic              done_o,
  output logic [DATA_W-1:0] quot_o
);

  localparam int CNT_W = $clog2(DATA_W);

  logic              busy_q, done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DATA_W-1:0] quo_q;
  logic [DV_W-1:0]   rem_q, dvs_q;
  logic [DV_W:0]     trial, diff;
  logic              ge;

  assign trial = {rem_q, quo_q[DATA_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DATA_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DV_W-1:0] : trial[DV_W-1:0];
      quo_q <= {quo_q[DATA_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider restarted while busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> done_q) else $error("divider finished without done");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("done held longer than one cycle");

endmodule

// ===== rtl/core/eevdf_task_picker_unit.sv =====
// Channel | Direction | Handshake                | Payload
// in      | input     | in_valid_i / in_stall_o  | op, slot, task_id, weight_req,
//         |           |                          | request_ticks, outcome
// out     | output    | out_valid_o / out_stall_i| status, found, chosen_slot, chosen_id
// cfg     | input     | cfg_we_i                 | cfg_wdata_i (quantum)
//
// One item at a time. create/wake/charge/set_attr: two passes through the
// shared 32-step serial divider. tick: divides only when the weight sum is
// nonzero and below the scale. pick: one table entry per cycle from the
// entry memory's single read port. Rejected items: an unknown op goes straight
// to the final state; failed checks pass through the read and check states.
// Reset clears modes, virtual time and weight sum at once; no clearing pass.
// The next item is taken while a result waits; the block stalls in its
// final state only if that earlier result is still held.
module eevdf_task_picker_unit import etp_pkg::*; #(
  parameter int ENTRIES     = ENTRIES_DEF,
  parameter int FIXED_SCALE = FIXED_SCALE_DEF,
  parameter int MAX_WEIGHT  = MAX_WEIGHT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  op_i,
  input  logic [5:0]  slot_i,
  input  logic [15:0] task_id_i,
  input  logic [3:0]  weight_req_i,
  input  logic [15:0] request_ticks_i,
  input  logic [1:0]  outcome_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        status_o,
  output logic        found_o,
  output logic [5:0]  chosen_slot_o,
  output logic [15:0] chosen_id_o
);

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int WSUM_W = $clog2(ENTRIES * MAX_WEIGHT + 1);
  localparam int DV_W   = (WSUM_W > WGT_W) ? WSUM_W : WGT_W;
  localparam logic [DATA_W-1:0] FS = DATA_W'(FIXED_SCALE);

  function automatic logic [WGT_W-1:0] clamp_w(input logic [3:0] w);
    logic [WGT_W-1:0] r;
    if (w == 4'd0) r = WGT_W'(1);
    else if (32'(w) > MAX_WEIGHT) r = WGT_W'(MAX_WEIGHT);
    else r = w[WGT_W-1:0];
    return r;
  endfunction

  state_e state_q, state_d;
  op_e    op_q;
  logic [5:0]  slot_q;
  logic [15:0] tid_q, req_q;
  logic [3:0]  wreq_q;
  logic [1:0]  outc_q;
  logic [15:0] quantum_q;
  logic [DATA_W-1:0] vt_q, vt_d;
  logic [WSUM_W-1:0] ws_q, ws_d;
  entry_t wrk_q, wrk_d;
  logic   phase_q, phase_d;
  logic   stat_q, stat_d;
  logic [DATA_W-1:0] prod_q, prod_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  mode_e  mode_q [ENTRIES];
  mode_e  mode_rd_q;
  entry_t mem [ENTRIES];
  entry_t rdata_q;

  logic [IDX_W-1:0] slot_idx, cnt_idx, rd_addr;
  logic   slot_ok;
  mode_e  mode_cur;
  logic   mode_we, mem_we, in_take, pick_issue, best_clr, res_load;
  mode_e  mode_wval;
  logic   div_start, div_done;
  logic [DATA_W-1:0] div_a, div_q, sres;
  logic [DV_W-1:0]   div_b;
  logic [WGT_W-1:0]  w_eff, cw;

  logic              v1_q, v2_q;
  mode_e             mode1_q;
  logic [IDX_W-1:0]  slot1_q, slot2_q, bslot_q;
  logic [DATA_W-1:0] t1_q, t2_q, dl_q, best_q, lag;
  logic              elt_q, run2_q, have_q, cand;
  logic [ID_W-1:0]   id2_q, bid_q;

  logic        out_valid_q, status_q, found_q;
  logic [5:0]  cslot_q;
  logic [15:0] cid_q;

  assign slot_ok  = 32'(slot_q) < ENTRIES;
  assign slot_idx = IDX_W'(slot_q);
  assign cnt_idx  = cnt_q[IDX_W-1:0];
  assign rd_addr  = (state_q == ST_PICK) ? cnt_idx : slot_idx;
  assign mode_cur = mode_rd_q;
  assign w_eff    = (wrk_q.weight == '0) ? WGT_W'(1) : wrk_q.weight;
  assign cw       = clamp_w(wreq_q);
  assign sres     = prod_q[DATA_W-1] ? (DATA_W'(0) - div_q) : div_q;

  etp_div #(.DV_W(DV_W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

  always_comb begin
    state_d    = state_q;
    vt_d       = vt_q;
    ws_d       = ws_q;
    wrk_d      = wrk_q;
    phase_d    = phase_q;
    stat_d     = stat_q;
    prod_d     = prod_q;
    cnt_d      = cnt_q;
    mode_we    = 1'b0;
    mode_wval  = MODE_FREE;
    mem_we     = 1'b0;
    in_take    = 1'b0;
    pick_issue = 1'b0;
    best_clr   = 1'b0;
    res_load   = 1'b0;
    div_start  = 1'b0;
    div_a      = prod_q[DATA_W-1] ? (DATA_W'(0) - prod_q) : prod_q;
    div_b      = DV_W'(w_eff);
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          in_take = 1'b1;
          stat_d  = 1'b1;
          case (op_e'(op_i))
            OP_PICK: begin
              stat_d   = 1'b0;
              cnt_d    = '0;
              best_clr = 1'b1;
              state_d  = ST_PICK;
            end
            OP_TICK: begin
              stat_d  = 1'b0;
              state_d = ST_TICK;
            end
            OP_CREATE, OP_WAKE, OP_CHARGE, OP_SETATTR: state_d = ST_READ;
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_READ: state_d = ST_CHECK;
      ST_CHECK: begin
        state_d = ST_DONE;
        phase_d = 1'b0;
        wrk_d   = rdata_q;
        case (op_q)
          OP_CREATE: begin
            if (slot_ok && mode_cur == MODE_FREE) begin
              stat_d         = 1'b0;
              wrk_d.id       = tid_q;
              wrk_d.weight   = cw;
              wrk_d.request  = req_q;
              wrk_d.vstart   = vt_q;
              wrk_d.used     = '0;
              ws_d           = ws_q + WSUM_W'(cw);
              mode_we        = 1'b1;
              mode_wval      = MODE_RUN;
              state_d        = ST_MUL;
            end
          end
          OP_WAKE: begin
            if (slot_ok && mode_cur == MODE_SLEEP) begin
              stat_d       = 1'b0;
              wrk_d.vstart = vt_q;
              wrk_d.used   = '0;
              ws_d         = ws_q + WSUM_W'(rdata_q.weight);
              mode_we      = 1'b1;
              mode_wval    = MODE_RUN;
              state_d      = ST_MUL;
            end
          end
          OP_CHARGE: begin
            if (slot_ok && mode_cur == MODE_RUN && outc_q <= OUTC_EXIT) begin
              stat_d     = 1'b0;
              wrk_d.used = rdata_q.used + DATA_W'(quantum_q);
              if (outc_q == OUTC_SLEEP || outc_q == OUTC_EXIT) begin
                ws_d      = ws_q - WSUM_W'(rdata_q.weight);
                mode_we   = 1'b1;
                mode_wval = (outc_q == OUTC_SLEEP) ? MODE_SLEEP : MODE_FREE;
              end
              state_d = ST_MUL;
            end
          end
          OP_SETATTR: begin
            if (slot_ok && mode_cur == MODE_RUN && req_q != '0) begin
              stat_d        = 1'b0;
              wrk_d.weight  = cw;
              wrk_d.request = req_q;
              wrk_d.vstart  = vt_q;
              wrk_d.used    = '0;
              ws_d          = ws_q + WSUM_W'(cw) - WSUM_W'(rdata_q.weight);
              state_d       = ST_MUL;
            end
          end
          default: state_d = ST_DONE;
        endcase
      end
      ST_MUL: begin
        prod_d  = DATA_W'((phase_q ? DATA_W'(wrk_q.request) : wrk_q.used) * FS);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        div_start = 1'b1;
        state_d   = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_done) begin
          if (op_q == OP_TICK) begin
            vt_d    = vt_q + div_q;
            state_d = ST_DONE;
          end else if (!phase_q) begin
            wrk_d.eligible = wrk_q.vstart + sres;
            phase_d        = 1'b1;
            state_d        = ST_MUL;
          end else begin
            wrk_d.deadline = wrk_q.eligible + sres;
            state_d        = ST_WRITE;
          end
        end
      end
      ST_WRITE: begin
        mem_we  = 1'b1;
        state_d = ST_DONE;
      end
      ST_TICK: begin
        if (ws_q == '0) begin
          state_d = ST_DONE;
        end else if (DATA_W'(ws_q) >= FS) begin
          vt_d    = vt_q + DATA_W'(1);
          state_d = ST_DONE;
        end else begin
          prod_d    = '0;
          div_a     = FS;
          div_b     = DV_W'(ws_q);
          div_start = 1'b1;
          state_d   = ST_WAIT;
        end
      end
      ST_PICK: begin
        pick_issue = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(ENTRIES - 1)) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!v1_q && !v2_q) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          res_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      quantum_q <= QUANTUM_RST;
      vt_q      <= '0;
      ws_q      <= '0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      have_q    <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) mode_q[i] <= MODE_FREE;
    end else begin
      state_q <= state_d;
      vt_q    <= vt_d;
      ws_q    <= ws_d;
      v1_q    <= pick_issue;
      v2_q    <= v1_q;
      if (cfg_we_i) quantum_q <= cfg_wdata_i;
      if (mode_we) mode_q[slot_idx] <= mode_wval;
      if (best_clr) have_q <= 1'b0;
      else if (v2_q && cand) have_q <= 1'b1;
      if (res_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[slot_idx] <= wrk_q;
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    wrk_q   <= wrk_d;
    phase_q <= phase_d;
    stat_q  <= stat_d;
    prod_q  <= prod_d;
    cnt_q   <= cnt_d;
    if (in_take) begin
      op_q   <= op_e'(op_i);
      slot_q <= slot_i;
      tid_q  <= task_id_i;
      wreq_q <= weight_req_i;
      req_q  <= request_ticks_i;
      outc_q <= outcome_i;
    end
    mode_rd_q <= mode_q[slot_idx];
    mode1_q <= mode_q[cnt_idx];
    slot1_q <= cnt_idx;
    t1_q    <= DATA_W'(DATA_W'(rdata_q.weight) * (vt_q - rdata_q.vstart));
    t2_q    <= DATA_W'(rdata_q.used * FS);
    elt_q   <= $signed(rdata_q.eligible) < $signed(vt_q);
    dl_q    <= rdata_q.deadline;
    id2_q   <= rdata_q.id;
    slot2_q <= slot1_q;
    run2_q  <= (mode1_q == MODE_RUN);
    if (res_load) begin
      status_q <= stat_q;
      found_q  <= (op_q == OP_PICK) && have_q;
      cslot_q  <= ((op_q == OP_PICK) && have_q) ? 6'(bslot_q) : 6'd0;
      cid_q    <= ((op_q == OP_PICK) && have_q) ? bid_q : 16'd0;
    end
  end

  assign lag  = t1_q - t2_q;
  assign cand = run2_q && (elt_q || !lag[DATA_W-1]);

  always_ff @(posedge clk_i) begin
    if (best_clr) begin
      best_q  <= DEADLINE_INIT;
      bslot_q <= '0;
      bid_q   <= '0;
    end else if (v2_q && cand) begin
      if ($signed(dl_q) < $signed(best_q) || (dl_q == best_q && !have_q)) begin
        best_q  <= dl_q;
        bslot_q <= slot2_q;
        bid_q   <= id2_q;
      end else if (dl_q == best_q && id2_q < bid_q) begin
        bslot_q <= slot2_q;
        bid_q   <= id2_q;
      end
    end
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign found_o       = found_q;
  assign chosen_slot_o = cslot_q;
  assign chosen_id_o   = cid_q;

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> !status_o) else $error("found item flagged rejected");
  a_wsum_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(ws_q) <= ENTRIES * MAX_WEIGHT) else $error("weight sum out of range");
  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PICK |-> 32'(cnt_q) < ENTRIES) else $error("scan ran past table");
  a_write_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> !stat_q && slot_ok) else $error("entry written on rejected item");

endmodule

// ===== tb/eevdf_picker_checker.sv =====
`timescale 1ns / 1ps
module eevdf_picker_checker import etp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  logic [2:0]  op_i,
  input  logic [5:0]  slot_i,
  input  logic [15:0] task_id_i,
  input  logic [3:0]  weight_req_i,
  input  logic [15:0] request_ticks_i,
  input  logic [1:0]  outcome_i,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic        status_o,
  input  logic        found_o,
  input  logic [5:0]  chosen_slot_o,
  input  logic [15:0] chosen_id_o,
  output int          fail_count,
  output int          pending,
  output int          picks_found
);

  localparam int SCALE = FIXED_SCALE_DEF;

  typedef struct packed {
    logic        status;
    logic        found;
    logic [5:0]  cslot;
    logic [15:0] cid;
  } verdict_t;

  verdict_t    verdict_q[$];
  logic [15:0] quantum;
  mode_e       mode [64];
  logic [15:0] tid [64];
  logic [31:0] wgt [64];
  logic [31:0] req [64];
  logic [31:0] vstart [64];
  logic [31:0] used [64];
  logic [31:0] elig [64];
  logic [31:0] dline [64];
  logic [31:0] vtime;
  logic [31:0] wsum;

  function automatic logic [31:0] scale_div(logic [31:0] a, logic [31:0] w);
    logic signed [31:0] p;
    p = a * SCALE;
    return p / $signed(w);
  endfunction

  function automatic logic [31:0] clamp_w(logic [3:0] w);
    if (w < 1) return 1;
    if (w > MAX_WEIGHT_DEF) return MAX_WEIGHT_DEF;
    return 32'(w);
  endfunction

  task automatic retime(int s);
    logic [31:0] w;
    w = (wgt[s] == 0) ? 1 : wgt[s];
    elig[s] = vstart[s] + scale_div(used[s], w);
    dline[s] = elig[s] + scale_div(req[s], w);
  endtask

  task automatic requeue(int s);
    vstart[s] = vtime;
    used[s] = 0;
    retime(s);
  endtask

  task automatic apply_event();
    verdict_t v;
    int s;
    logic signed [31:0] best, lag, dl;
    logic have;
    int bs;
    v = '0;
    v.status = 1'b1;
    s = int'(slot_i);
    case (op_i)
      OP_CREATE: if (mode[s] == MODE_FREE) begin
        tid[s] = task_id_i;
        wgt[s] = clamp_w(weight_req_i);
        req[s] = 32'(request_ticks_i);
        wsum += wgt[s];
        mode[s] = MODE_RUN;
        requeue(s);
        v.status = 1'b0;
      end
      OP_WAKE: if (mode[s] == MODE_SLEEP) begin
        mode[s] = MODE_RUN;
        wsum += wgt[s];
        requeue(s);
        v.status = 1'b0;
      end
      OP_CHARGE: if (mode[s] == MODE_RUN && outcome_i <= OUTC_EXIT) begin
        used[s] += 32'(quantum);
        retime(s);
        if (outcome_i != OUTC_YIELD) begin
          wsum -= wgt[s];
          mode[s] = (outcome_i == OUTC_SLEEP) ? MODE_SLEEP : MODE_FREE;
        end
        v.status = 1'b0;
      end
      OP_SETATTR: if (mode[s] == MODE_RUN && request_ticks_i != 0) begin
        wsum = wsum + clamp_w(weight_req_i) - wgt[s];
        req[s] = 32'(request_ticks_i);
        wgt[s] = clamp_w(weight_req_i);
        requeue(s);
        v.status = 1'b0;
      end
      OP_PICK: begin
        v.status = 1'b0;
        best = DEADLINE_INIT;
        have = 1'b0;
        bs = 0;
        for (int i = 0; i < 64; i++) begin
          if (mode[i] != MODE_RUN) continue;
          lag = wgt[i] * (vtime - vstart[i]) - used[i] * SCALE;
          if ($signed(elig[i]) < $signed(vtime)) lag = 0;
          if (lag < 0) continue;
          dl = dline[i];
          if (dl < best || (dl == best && !have)) begin
            best = dl;
            bs = i;
            have = 1'b1;
          end else if (dl == best && tid[i] < tid[bs]) begin
            bs = i;
          end
        end
        if (have) begin
          v.found = 1'b1;
          v.cslot = 6'(bs);
          v.cid = tid[bs];
        end
      end
      OP_TICK: begin
        v.status = 1'b0;
        if (wsum > 0) vtime += (wsum >= SCALE) ? 1 : SCALE / wsum;
      end
      default: ;
    endcase
    verdict_q.push_back(v);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t e;
    if (!rst_ni) begin
      quantum = QUANTUM_RST;
      foreach (mode[i]) mode[i] = MODE_FREE;
      vtime = 0;
      wsum = 0;
      fail_count = 0;
      picks_found = 0;
      pending = 0;
      verdict_q.delete();
    end else begin
      if (cfg_we_i) quantum = cfg_wdata_i;
      if (out_valid_o && !out_stall_i) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected result status=%0b found=%0b slot=%0d id=%0d",
                   $time, status_o, found_o, chosen_slot_o, chosen_id_o);
          fail_count++;
        end else begin
          e = verdict_q.pop_front();
          if (e.found) picks_found++;
          if (e != {status_o, found_o, chosen_slot_o, chosen_id_o}) begin
            $display("%0t: expected %0b/%0b/%0d/%0d, got %0b/%0b/%0d/%0d",
                     $time, e.status, e.found, e.cslot, e.cid,
                     status_o, found_o, chosen_slot_o, chosen_id_o);
            fail_count++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) apply_event();
      pending = verdict_q.size();
    end
  end

endmodule

// ===== tb/tb_eevdf_task_picker_unit.sv =====
`timescale 1ns / 1ps
module tb_eevdf_task_picker_unit import etp_pkg::*;;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [15:0] cfg_wdata_i = 0;
  logic        in_valid_i = 0;
  logic        in_stall_o;
  logic [2:0]  op_i = 0;
  logic [5:0]  slot_i = 0;
  logic [15:0] task_id_i = 0;
  logic [3:0]  weight_req_i = 0;
  logic [15:0] request_ticks_i = 0;
  logic [1:0]  outcome_i = 0;
  logic        out_valid_o;
  logic        out_stall_i = 0;
  logic        status_o, found_o;
  logic [5:0]  chosen_slot_o;
  logic [15:0] chosen_id_o;
  int          fail_count, pending, picks_found;
  int          hold_off = 0;
  logic        hold_done = 0;
  int          sent = 0;

  always #1 clk_i = ~clk_i;

  eevdf_task_picker_unit i_dut (.*);
  eevdf_picker_checker i_chk (.*);

  // receiver stall pattern; one long stall once the sender is well under way
  always @(posedge clk_i) begin
    int m;
    if (hold_off > 0) begin
      out_stall_i <= 1'b1;
      hold_off <= hold_off - 1;
    end else if (sent == 225 && !hold_done) begin
      out_stall_i <= 1'b1;
      hold_off <= 400;
      hold_done <= 1'b1;
    end else begin
      m = (sent / 100) % 3;
      out_stall_i <= (m == 0) ? 1'b0 : ($urandom_range(0, 3) < m);
    end
  end

  task automatic send(int op, int s, int id, int w, int r, int oc);
    op_i <= 3'(op);
    slot_i <= 6'(s);
    task_id_i <= 16'(id);
    weight_req_i <= 4'(w);
    request_ticks_i <= 16'(r);
    outcome_i <= 2'(oc);
    in_valid_i <= 1;
    do @(posedge clk_i); while (in_stall_o);
    sent++;
  endtask

  task automatic pause();
    in_valid_i <= 0;
    repeat ($urandom_range(1, 6)) @(posedge clk_i);
  endtask

  task automatic drain_and_set(int q);
    in_valid_i <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    cfg_we_i <= 1;
    cfg_wdata_i <= 16'(q);
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  task automatic random_item(int focus);
    int k;
    int s;
    k = $urandom_range(0, 99);
    s = $urandom_range(0, focus);
    if (k < 22) send(OP_CREATE, s, $urandom, $urandom, $urandom_range(0, 3) == 0 ?
                     $urandom : $urandom_range(0, 40), $urandom);
    else if (k < 32) send(OP_WAKE, s, $urandom, $urandom, $urandom, $urandom);
    else if (k < 52) send(OP_CHARGE, s, $urandom, $urandom, $urandom,
                          $urandom_range(0, 9) == 0 ? 3 : $urandom_range(0, 2));
    else if (k < 60) send(OP_SETATTR, s, $urandom, $urandom,
                          $urandom_range(0, 5) == 0 ? 0 : $urandom, $urandom);
    else if (k < 80) send(OP_PICK, $urandom, $urandom, $urandom, $urandom, $urandom);
    else if (k < 95) send(OP_TICK, $urandom, $urandom, $urandom, $urandom, $urandom);
    else send($urandom_range(6, 7), $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed
    send(OP_PICK, 0, 0, 0, 0, 0);
    send(OP_TICK, 0, 0, 0, 0, 0);
    send(OP_WAKE, 3, 0, 0, 0, 0);
    send(OP_CHARGE, 3, 0, 0, 0, 0);
    send(OP_CREATE, 0, 16'hFFFF, 4'hF, 16'hFFFF, 0);
    send(OP_CREATE, 0, 1, 1, 1, 0);
    send(OP_CREATE, 63, 0, 0, 0, 0);
    send(OP_CREATE, 5, 16'h0000, 4'd3, 16'd0, 0);
    send(OP_PICK, 0, 0, 0, 0, 0);
    send(OP_TICK, 0, 0, 0, 0, 0);
    send(OP_CHARGE, 0, 0, 0, 0, 3);
    send(OP_CHARGE, 0, 0, 0, 0, OUTC_YIELD);
    send(OP_SETATTR, 63, 0, 4'd2, 16'd0, 0);
    send(OP_SETATTR, 63, 0, 4'd2, 16'd500, 0);
    send(OP_PICK, 0, 0, 0, 0, 0);
    send(OP_CHARGE, 5, 0, 0, 0, OUTC_SLEEP);
    send(OP_WAKE, 5, 0, 0, 0, 0);
    send(OP_CHARGE, 5, 0, 0, 0, OUTC_EXIT);
    send(OP_SETATTR, 5, 0, 1, 7, 0);
    send(6, 0, 0, 0, 0, 0);
    send(7, 0, 0, 0, 0, 0);
    send(OP_PICK, 0, 0, 0, 0, 0);
    drain_and_set(0);
    send(OP_CHARGE, 0, 0, 0, 0, OUTC_YIELD);
    send(OP_PICK, 0, 0, 0, 0, 0);
    drain_and_set(16'hFFFF);
    for (int i = 0; i < 640; i++) begin
      if (i == 160) drain_and_set(1);
      if (i == 320) drain_and_set($urandom_range(1, 3000));
      if (i == 480) drain_and_set(int'(QUANTUM_RST));
      if (i > 200 && i < 215) begin
        random_item(63);
        continue;
      end
      random_item(i % 200 < 100 ? 7 : 63);
      if ($urandom_range(0, 9) == 0 && (i / 50) % 2 == 1) pause();
    end
    in_valid_i <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("Sent %0d items across several quantum settings; %0d picks found a task.",
             sent, picks_found);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/etp_pkg.sv
rtl/core/etp_div.sv
rtl/core/eevdf_task_picker_unit.sv
tb/eevdf_picker_checker.sv
tb/tb_eevdf_task_picker_unit.sv
